FILE: hw/rtl/crcwd_pkg.sv
// ----------------------------------------------------------------------------
// crcwd_pkg
// Shared types, constants and the CRC-8 byte step for the word deframer.
// ----------------------------------------------------------------------------
package crcwd_pkg;

   localparam int MAX_WORDS = 8;           // longest frame supported, in words
   localparam int IDX_W     = 3;           // word index width
   localparam int LEN_W     = 4;           // frame length register width

   // longest usable frame: limited by MAX_WORDS and by the index width
   localparam int LEN_LIMIT_I = (MAX_WORDS < (1 << IDX_W)) ? MAX_WORDS : (1 << IDX_W);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_LIMIT_I);
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(2);

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // byte position inside a triple
   localparam logic [1:0] PH_HIGH = 2'd0;
   localparam logic [1:0] PH_LOW  = 2'd1;
   localparam logic [1:0] PH_CRC  = 2'd2;

   typedef struct packed {
      logic [15:0]      word_value;
      logic [IDX_W-1:0] word_index;
      logic             crc_ok;
      logic             frame_ok;
      logic             last_word;
   } result_type;

   // one byte through the MSB-first CRC-8 shift register
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   // register value mapped into 1 .. LEN_LIMIT
   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] n);
      logic [LEN_W-1:0] r;
      r = n;
      if (r == '0) begin
         r = LEN_W'(1);
      end else if (r > LEN_LIMIT) begin
         r = LEN_LIMIT;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/crcwd_core.sv
// ----------------------------------------------------------------------------
// crcwd_core
// Triple tracking state, CRC check and word assembly for one byte per cycle while advance is high.
// ----------------------------------------------------------------------------
module crcwd_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic [7:0]                           data_byte,
   input  logic                                 frame_start,
   input  logic [crcwd_pkg::LEN_W-1:0]          words_per_frame,
   output logic                                 emit,
   output crcwd_pkg::result_type                result
);

   logic [1:0]                    phase_ff, phase_in;
   logic [7:0]                    crc_ff, crc_in;
   logic [7:0]                    high_ff, high_in;
   logic [7:0]                    low_ff, low_in;
   logic [crcwd_pkg::IDX_W-1:0]   wcnt_ff, wcnt_in;
   logic                          good_ff, good_in;

   logic [1:0]                    phase_eff;
   logic [7:0]                    crc_eff;
   logic [crcwd_pkg::IDX_W-1:0]   wcnt_eff;
   logic                          good_eff;
   logic [crcwd_pkg::LEN_W-1:0]   len;
   logic [crcwd_pkg::LEN_W-1:0]   idx_next;
   logic                          crc_match;
   logic                          fok;
   logic                          last;

   // frame start restarts the counters before the byte is taken
   assign phase_eff = frame_start ? crcwd_pkg::PH_HIGH : phase_ff;
   assign crc_eff   = frame_start ? crcwd_pkg::CRC_INIT : crc_ff;
   assign wcnt_eff  = frame_start ? '0 : wcnt_ff;
   assign good_eff  = frame_start | good_ff;

   assign len       = crcwd_pkg::eff_len(words_per_frame);
   assign idx_next  = {{(crcwd_pkg::LEN_W-crcwd_pkg::IDX_W){1'b0}}, wcnt_eff}
                      + crcwd_pkg::LEN_W'(1);
   assign crc_match = (crc_eff == data_byte);
   assign fok       = crc_match & good_eff;
   assign last      = (idx_next >= len);

   always_comb begin
      phase_in = phase_ff;
      crc_in   = crc_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      wcnt_in  = wcnt_ff;
      good_in  = good_ff;
      emit     = 1'b0;
      case (phase_eff)
         crcwd_pkg::PH_LOW: begin
            low_in   = data_byte;
            crc_in   = crcwd_pkg::crc8_byte(crc_eff, data_byte);
            phase_in = crcwd_pkg::PH_CRC;
            wcnt_in  = wcnt_eff;
            good_in  = good_eff;
         end
         crcwd_pkg::PH_CRC: begin
            emit     = 1'b1;
            phase_in = crcwd_pkg::PH_HIGH;
            crc_in   = crcwd_pkg::CRC_INIT;
            wcnt_in  = last ? '0 : idx_next[crcwd_pkg::IDX_W-1:0];
            good_in  = last | fok;
         end
         default: begin
            // high byte; the unused phase code lands here as well
            high_in  = data_byte;
            crc_in   = crcwd_pkg::crc8_byte(crcwd_pkg::CRC_INIT, data_byte);
            phase_in = crcwd_pkg::PH_LOW;
            wcnt_in  = wcnt_eff;
            good_in  = good_eff;
         end
      endcase
   end

   always_comb begin
      result.word_value = {high_ff, low_ff};
      result.word_index = wcnt_eff;
      result.crc_ok     = crc_match;
      result.frame_ok   = fok;
      result.last_word  = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= crcwd_pkg::PH_HIGH;
         crc_ff   <= crcwd_pkg::CRC_INIT;
         high_ff  <= '0;
         low_ff   <= '0;
         wcnt_ff  <= '0;
         good_ff  <= 1'b1;
      end else if (advance) begin
         phase_ff <= phase_in;
         crc_ff   <= crc_in;
         high_ff  <= high_in;
         low_ff   <= low_in;
         wcnt_ff  <= wcnt_in;
         good_ff  <= good_in;
      end
   end

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      advance && emit && result.last_word |=> (wcnt_ff == '0) && good_ff)
      else $error("word counter not restarted after last word");

   a_start_to_low: assert property (@(posedge clock) disable iff (reset)
      advance && frame_start |=> (phase_ff == crcwd_pkg::PH_LOW))
      else $error("frame start byte not taken as high byte");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(wcnt_ff) && $stable(crc_ff))
      else $error("state moved without an item");

endmodule

FILE: hw/rtl/crc8_checked_word_deframer.sv
// ----------------------------------------------------------------------------
// crc8_checked_word_deframer
// Byte stream to CRC-8 checked 16-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one frame byte per item, req_frame_start on the first byte of a
//            frame. Each word is a triple of high byte, low byte, CRC byte.
//   rsp_*  : one item after each CRC byte: the word, its index, crc_ok,
//            frame_ok (all words so far good) and last_word.
//   csr_*  : frame length in words, written while the block is idle; 0 acts
//            as 1 and values above the supported maximum saturate.
// Path: the CRC byte is captured in the input register, checked by the core
//   and the result is registered in the result register that drives rsp_*.
// Throughput: 1 byte per cycle while the result register is not stalled;
//   each byte takes one CRC-8 byte step between the input register and core.
// Reset: synchronous; clears the valid flags of both pipeline registers,
//   restarts the CRC and counters and sets the frame length to 2 words.
// Stall: a stalled result holds; req_stall rises only while a byte waits in
//   the input register and the result register is stalled.
// ----------------------------------------------------------------------------
module crc8_checked_word_deframer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_frame_start,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [15:0]                   rsp_word_value,
   output logic [crcwd_pkg::IDX_W-1:0]   rsp_word_index,
   output logic                          rsp_crc_ok,
   output logic                          rsp_frame_ok,
   output logic                          rsp_last_word,
   input  logic                          csr_wr_en,
   input  logic [crcwd_pkg::LEN_W-1:0]   csr_wr_data
);

   logic                          in_vld_ff, in_vld_in;
   logic [7:0]                    in_byte_ff;
   logic                          in_start_ff;
   logic                          out_vld_ff, out_vld_in;
   crcwd_pkg::result_type         out_ff;
   logic [crcwd_pkg::LEN_W-1:0]   len_ff;

   logic                          out_free;
   logic                          advance;
   logic                          accept;
   logic                          emit;
   crcwd_pkg::result_type         result;

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign in_vld_in  = accept | (in_vld_ff & !advance);
   assign out_vld_in = out_free ? (advance & emit) : 1'b1;

   crcwd_core u_core (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .data_byte       (in_byte_ff),
      .frame_start     (in_start_ff),
      .words_per_frame (len_ff),
      .emit            (emit),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         len_ff     <= crcwd_pkg::LEN_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_frame_start;
      end
      if (advance && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_word_value = out_ff.word_value;
   assign rsp_word_index = out_ff.word_index;
   assign rsp_crc_ok     = out_ff.crc_ok;
   assign rsp_frame_ok   = out_ff.frame_ok;
   assign rsp_last_word  = out_ff.last_word;

   a_frame_ok_needs_crc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_frame_ok || rsp_crc_ok))
      else $error("frame_ok set on a word that failed CRC");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && rsp_stall |-> !advance)
      else $error("result register advanced while stalled");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && out_vld_ff)
      else $error("input stalled with room in the pipeline");

endmodule
